// ===== hdl/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Concurrent assertion wrappers for the ordered set table checker.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define OST_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ordered set table assertion failed");

// The expression must never be true outside reset.
`define OST_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ordered set table forbidden condition seen");

`endif

// ===== hdl/ost_pkg.sv =====
// ============================================================================
// Ordered set table package
// Field widths, operation and status codes, and the cell control bundle.
// ============================================================================
`default_nettype none

package ost_pkg;

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int CNT_W    = 5;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MEMBER  = 2'd2;
    localparam logic [OP_W-1:0] OP_ORDINAL = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic compare;    // latch the match flag against the current key
        logic insert_go;  // every cell takes its left neighbor's value
        logic remove_go;  // cells at or past the hit take their right neighbor
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/ost_cell.sv =====
// ============================================================================
// Ordered set table cell
// One slot of the table: holds a value, compares it with the key, and
// shifts toward either neighbor on insert or remove.
// ============================================================================
`default_nettype none

module ost_cell
    import ost_pkg::*;
#(
    parameter int POS_W = 5,
    parameter int INDEX = 0
) (
    input  wire logic                      clk,
    input  wire cell_ctrl_t                ctrl,
    input  wire logic signed [VALUE_W-1:0] key,
    input  wire logic signed [VALUE_W-1:0] left_data,
    input  wire logic signed [VALUE_W-1:0] right_data,
    input  wire logic        [POS_W-1:0]   occupancy,
    input  wire logic        [POS_W-1:0]   hit_pos,
    output logic signed      [VALUE_W-1:0] slot_data,
    output logic                           match
);

    localparam logic [POS_W:0] MY_IDX = (POS_W+1)'(INDEX);
    localparam logic [POS_W:0] MY_POS = (POS_W+1)'(INDEX + 1);

    logic signed [VALUE_W-1:0] slot_reg;
    logic                      match_reg;
    logic                      cell_valid;
    logic                      take_right;

    // Only cells below the fill level hold live values.
    assign cell_valid = MY_IDX < {1'b0, occupancy};
    // A removal closes the gap from the hit cell to the back of the chain.
    assign take_right = ctrl.remove_go && (MY_POS >= {1'b0, hit_pos});

    always_ff @(posedge clk)
    begin
        if (ctrl.insert_go)
        begin
            slot_reg <= left_data;
        end
        else if (take_right)
        begin
            slot_reg <= right_data;
        end
        if (ctrl.compare)
        begin
            match_reg <= cell_valid && (slot_reg == key);
        end
    end

    assign slot_data = slot_reg;
    assign match     = match_reg;

endmodule

`default_nettype wire

// ===== hdl/ost_encode.sv =====
// ============================================================================
// Ordered set table hit encoder
// Turns the per-cell match flags into a hit flag and a 1-based position.
// ============================================================================
`default_nettype none

module ost_encode #(
    parameter int CAPACITY = 16,
    parameter int POS_W    = 5
) (
    input  wire logic [CAPACITY-1:0] match,
    output logic                     hit,
    output logic [POS_W-1:0]         hit_pos
);

    // Stored values are distinct, so at most one flag is set and an OR of
    // the candidate positions gives the position of that one.
    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match[i])
            begin
                hit_pos = hit_pos | POS_W'(i + 1);
            end
        end
    end

    assign hit = |match;

endmodule

`default_nettype wire

// ===== hdl/ordered_set_table_top.sv =====
// ============================================================================
// Ordered set table
// Insertion-ordered set of distinct 32-bit values built as a chain of cells.
// ============================================================================
// Usage:
// The input channel carries one item (op, value) per handshake; an item is
// taken when in_valid is high and in_stall is low. Ops are insert, remove,
// membership query and ordinal query. Every item yields exactly one result
// item (found, position, count, status) on the output channel, taken when
// out_valid is high and out_stall is low.
// An item moves through three steps after it is taken: every cell compares
// its slot with the key, the match flags are encoded into a position, and
// the chain shifts (insert at the front or close the gap on remove) while
// the result is loaded into the output register. The next item can be taken
// once the result has left the update step and the sequencer is back in
// idle. The sequencer holds one item at a time and takes no new item before
// the cell chain has shifted for the last one.
// When the receiver stalls, the result is held and the finished item waits
// in the update step, while an item already in the output register does not
// keep the block from taking the next input.
// Reset empties the table and drops any item in flight; slot contents are
// not cleared, since only slots below the fill level are ever compared.
// ============================================================================
`default_nettype none

module ordered_set_table_top
    import ost_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic        [OP_W-1:0]    op,
    input  wire logic signed [VALUE_W-1:0] value,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           found,
    output logic             [CNT_W-1:0]   position,
    output logic             [CNT_W-1:0]   count,
    output logic             [STATUS_W-1:0] status
);

    // Width that holds any fill level from zero up to the capacity.
    localparam int POS_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_ENC  = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    logic [1:0]                state_reg, state_next;
    logic [OP_W-1:0]           op_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      found_reg;
    logic [POS_W-1:0]          pos_reg;
    logic [POS_W-1:0]          occ_reg, occ_next;
    logic                      out_valid_reg;
    logic                      out_found_reg;
    logic [CNT_W-1:0]          out_pos_reg;
    logic [CNT_W-1:0]          out_cnt_reg;
    logic [STATUS_W-1:0]       out_status_reg;

    logic                      in_take;
    logic                      out_free;
    logic                      commit;
    logic                      is_full;
    logic                      enc_hit;
    logic [POS_W-1:0]          enc_pos;
    logic [STATUS_W-1:0]       status_next;
    cell_ctrl_t                ctrl;

    logic signed [VALUE_W-1:0] slot_data [CAPACITY];
    logic [CAPACITY-1:0]       match_vec;

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;
    assign commit   = (state_reg == S_UPD) && out_free;
    assign is_full  = (occ_reg >= POS_W'(CAPACITY));

    // Cell control: compare in the first step, shift on the committing cycle.
    always_comb
    begin
        ctrl.compare   = (state_reg == S_CMP);
        ctrl.insert_go = commit && (op_reg == OP_INSERT) && !found_reg && !is_full;
        ctrl.remove_go = commit && (op_reg == OP_REMOVE) && found_reg;
    end

    // Fill level after the operation and the status of the result.
    always_comb
    begin
        occ_next    = occ_reg;
        status_next = ST_OK;
        case (op_reg)
            OP_INSERT:
            begin
                if (!found_reg)
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        occ_next = occ_reg + POS_W'(1);
                    end
                end
            end
            OP_REMOVE:
            begin
                if (found_reg)
                begin
                    occ_next = occ_reg - POS_W'(1);
                end
                else
                begin
                    status_next = ST_ABSENT;
                end
            end
            OP_MEMBER, OP_ORDINAL:
            begin
                if (occ_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:   state_next = S_ENC;
            S_ENC:   state_next = S_UPD;
            S_UPD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                occ_reg       <= occ_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: item key, encoded hit and the result item.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg    <= op;
            value_reg <= value;
        end
        if (state_reg == S_ENC)
        begin
            found_reg <= enc_hit;
            pos_reg   <= enc_pos;
        end
        if (commit)
        begin
            out_found_reg  <= found_reg;
            out_pos_reg    <= found_reg ? CNT_W'(pos_reg) : CNT_W'(occ_reg);
            out_cnt_reg    <= CNT_W'(occ_next);
            out_status_reg <= status_next;
        end
    end

    // The chain: cell 0 is the front and takes the key on insert; the last
    // cell has no right neighbor and keeps its own value on remove.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_in;
        logic signed [VALUE_W-1:0] right_in;

        if (g == 0)
        begin : g_front
            assign left_in = value_reg;
        end
        else
        begin : g_inner_left
            assign left_in = slot_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_back
            assign right_in = slot_data[g];
        end
        else
        begin : g_inner_right
            assign right_in = slot_data[g+1];
        end

        ost_cell #(
            .POS_W (POS_W),
            .INDEX (g)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .key        (value_reg),
            .left_data  (left_in),
            .right_data (right_in),
            .occupancy  (occ_reg),
            .hit_pos    (pos_reg),
            .slot_data  (slot_data[g]),
            .match      (match_vec[g])
        );
    end

    ost_encode #(
        .CAPACITY (CAPACITY),
        .POS_W    (POS_W)
    ) u_encode (
        .match   (match_vec),
        .hit     (enc_hit),
        .hit_pos (enc_pos)
    );

    assign out_valid = out_valid_reg;
    assign found     = out_found_reg;
    assign position  = out_pos_reg;
    assign count     = out_cnt_reg;
    assign status    = out_status_reg;

endmodule

`default_nettype wire

// ===== hdl/ost_checker.sv =====
// ============================================================================
// Ordered set table checker
// Port-level assertions on the result channel, bound to the top level.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module ost_checker
    import ost_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic                      found,
    input wire logic        [CNT_W-1:0]   position,
    input wire logic        [CNT_W-1:0]   count,
    input wire logic        [STATUS_W-1:0] status
);

    // A stalled result stays on the port unchanged.
    `OST_ASSERT(a_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(found) && $stable(position) && $stable(count) && $stable(status))

    // The block works on one item at a time once it has taken one.
    `OST_ASSERT(a_busy, clk, rst_n, in_valid && !in_stall |=> in_stall)

    // A query on an empty table reports nothing present and nothing stored.
    `OST_ASSERT(a_empty, clk, rst_n, out_valid && (status == ST_EMPTY) |-> !found && (position == '0) && (count == '0))

    // A dropped insert means the value was absent and the table stayed full.
    `OST_ASSERT_NEVER(a_full, clk, rst_n, out_valid && (status == ST_FULL) && (found || ((CAPACITY < 32) && (count != CNT_W'(CAPACITY)))))

endmodule

bind ordered_set_table_top ost_checker #(
    .CAPACITY (CAPACITY)
) u_ost_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .position  (position),
    .count     (count),
    .status    (status)
);

`default_nettype wire
